[src/prc_pkg.sv]
// ----------------------------------------------------------------------------
// prc_pkg
// Types and constants of the planar run-length to chunky pixel decoder.
// ----------------------------------------------------------------------------
package prc_pkg;

	// Upper bounds of the row store and defaults of the top-level parameters.
	localparam int ROW_CAP          = 64;
	localparam int DEFAULT_ROW_BYTES = 64;
	localparam int DEFAULT_PLANES    = 8;

	// Field widths fixed by the interface.
	localparam int BYTE_W   = 8;
	localparam int WIDTH_W  = 10;
	localparam int ROWS_W   = 16;
	localparam int PLANES_W = 4;
	localparam int PIDX_W   = 3;
	localparam int RUN_W    = 8;
	localparam int CFG_W    = 16;
	localparam int CIDX_W   = 2;

	// ByteRun1 control code that does nothing.
	localparam logic [BYTE_W-1:0] CTRL_NOP = 8'h80;

	// Register reset values.
	localparam logic [WIDTH_W-1:0]  RST_WIDTH      = 10'd320;
	localparam logic [ROWS_W-1:0]   RST_ROWS       = 16'd200;
	localparam logic [PLANES_W-1:0] RST_PLANES     = 4'd8;
	localparam logic                RST_COMPRESSED = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		CFG_WIDTH      = 2'd0,
		CFG_ROWS       = 2'd1,
		CFG_PLANES     = 2'd2,
		CFG_COMPRESSED = 2'd3
	} cfg_idx_t;

	// Run-length decoder phase.
	typedef enum logic [1:0] {
		PH_CONTROL = 2'd0,
		PH_LITERAL = 2'd1,
		PH_REPEAT  = 2'd2,
		PH_SKIP    = 2'd3
	} phase_t;

	// Sequencer state: taking bytes, or expanding a repeat run.
	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_REPEAT = 1'b1
	} state_t;

endpackage

[src/planar_rle_to_chunky_decoder.sv]
// ----------------------------------------------------------------------------
// planar_rle_to_chunky_decoder
// Decodes an interleaved bitplane image body, raw or ByteRun1 coded, into
// columns of eight chunky pixels. Earlier planes of a row wait in a row store.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | in_valid / in_stall     | body_byte
//  output   | out_valid / out_stall   | pix0..pix7, valid_pixels, end_of_row,
//           |                         | end_of_image, last_of_run
//  config   | cfg_we                  | cfg_index, cfg_data
//
//  A raw byte, a literal byte or a control byte is taken whole, so the body
//  streams at one request per cycle while the result register is not full and
//  stalled. A repeat run is expanded one copy per cycle on the single row store
//  port; input stalls meanwhile. A copy that makes a pixel result also waits
//  while the result register is full and stalled. The row store needs no
//  clearing after reset, so a request can be taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module planar_rle_to_chunky_decoder import prc_pkg::*; #(
	parameter int MAX_ROW_BYTES = DEFAULT_ROW_BYTES,
	parameter int MAX_PLANES    = DEFAULT_PLANES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [BYTE_W-1:0]   body_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [BYTE_W-1:0]   pix0,
	output logic [BYTE_W-1:0]   pix1,
	output logic [BYTE_W-1:0]   pix2,
	output logic [BYTE_W-1:0]   pix3,
	output logic [BYTE_W-1:0]   pix4,
	output logic [BYTE_W-1:0]   pix5,
	output logic [BYTE_W-1:0]   pix6,
	output logic [BYTE_W-1:0]   pix7,
	output logic [3:0]          valid_pixels,
	output logic                end_of_row,
	output logic                end_of_image,
	output logic                last_of_run,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	localparam int ROW_LIM_A = (MAX_ROW_BYTES > ROW_CAP) ? ROW_CAP : MAX_ROW_BYTES;
	localparam int ROW_LIM_E = (ROW_LIM_A / 2) * 2;
	localparam int ROW_LIM   = (ROW_LIM_E < 2) ? 2 : ROW_LIM_E;
	localparam int CW        = $clog2(ROW_LIM);
	localparam int RBW       = $clog2(ROW_LIM + 1);
	localparam int LW        = (MAX_PLANES > 1) ? MAX_PLANES - 1 : 1;
	localparam int LIW       = (LW > 1) ? $clog2(LW) : 1;

	// Configuration registers.
	logic [WIDTH_W-1:0]  width_q;
	logic [ROWS_W-1:0]   rows_q;
	logic [PLANES_W-1:0] planes_q;
	logic                compressed_q;

	// Decoder state.
	state_t              st_q, st_d;
	phase_t              phase_q, phase_d;
	logic [RUN_W-1:0]    run_q, run_d;
	logic [CW-1:0]       column_q, column_d;
	logic [PIDX_W-1:0]   plane_q, plane_d;
	logic [ROWS_W-1:0]   row_q, row_d;
	logic                done_q, done_d;
	logic [BYTE_W-1:0]   rep_byte_q, rep_byte_d;
	logic [RUN_W-1:0]    rep_cnt_q, rep_cnt_d;

	// Row store: one lane per earlier plane.
	logic [LW-1:0][BYTE_W-1:0] row_mem [ROW_LIM];
	logic [LW-1:0][BYTE_W-1:0] rdata_s1;
	logic                      mem_we;

	// Result register.
	logic                      out_valid_q;
	logic [7:0][BYTE_W-1:0]    pix_q;
	logic [3:0]                valid_q;
	logic                      eor_q, eoi_q, lor_q;

	// Working values of one placed byte.
	logic                      in_acc, emit_ok, put, last_copy, out_load;
	logic [BYTE_W-1:0]         v;
	logic [PLANES_W-1:0]       pc_eff;
	logic                      last_plane;
	logic [BYTE_W-1:0]         rb_raw;
	logic [BYTE_W:0]           rb_even;
	logic [RBW-1:0]            rb;
	logic [WIDTH_W:0]          rb_pix, effw, base, diff;
	logic [3:0]                valid_n;
	logic                      eor_n, eoi_n;
	logic [CW:0]               col_inc;
	logic [CW-1:0]             col_n;
	logic [PLANES_W-1:0]       plane_inc;
	logic [PIDX_W-1:0]         plane_n;
	logic [ROWS_W-1:0]         row_n;
	logic                      done_n, plane_end;
	logic [7:0][BYTE_W-1:0]    pbytes;
	logic [7:0][BYTE_W-1:0]    pix_n;
	logic [RUN_W-1:0]          run_dec;

	assign in_acc  = in_valid && !in_stall;
	assign emit_ok = !out_valid_q || !out_stall;

	// Row geometry and the effect of placing one byte at the current position.
	always_comb begin
		pc_eff = planes_q;
		if (planes_q == '0) pc_eff = PLANES_W'(1);
		if (planes_q > PLANES_W'(MAX_PLANES)) pc_eff = PLANES_W'(MAX_PLANES);
		last_plane = (PLANES_W'(plane_q) + PLANES_W'(1)) == pc_eff;

		rb_raw  = BYTE_W'((WIDTH_W+1)'(width_q) + (WIDTH_W+1)'(7) >> 3);
		rb_even = (BYTE_W+1)'(rb_raw) + (BYTE_W+1)'(rb_raw[0]);
		if (rb_even > (BYTE_W+1)'(ROW_LIM)) rb = RBW'(ROW_LIM);
		else if (rb_even == '0) rb = RBW'(2);
		else rb = RBW'(rb_even);

		rb_pix = (WIDTH_W+1)'({rb, 3'b000});
		effw   = ((WIDTH_W+1)'(width_q) > rb_pix) ? rb_pix : (WIDTH_W+1)'(width_q);
		base   = (WIDTH_W+1)'({column_q, 3'b000});
		diff   = effw - base;
		if (effw > base) valid_n = (diff > (WIDTH_W+1)'(8)) ? 4'd8 : diff[3:0];
		else valid_n = 4'd0;

		col_inc = (CW+1)'(column_q) + (CW+1)'(1);
		eor_n   = (RBW+1)'(col_inc) >= (RBW+1)'(rb);
		eoi_n   = eor_n && ((ROWS_W+1)'(row_q) + (ROWS_W+1)'(1) >= (ROWS_W+1)'(rows_q));

		col_n     = col_inc[CW-1:0];
		plane_n   = plane_q;
		row_n     = row_q;
		done_n    = done_q;
		plane_end = 1'b0;
		plane_inc = PLANES_W'(plane_q) + PLANES_W'(1);
		if (eor_n) begin
			col_n     = '0;
			plane_end = 1'b1;
			plane_n   = plane_inc[PIDX_W-1:0];
			if (plane_inc >= pc_eff) begin
				plane_n = '0;
				row_n   = row_q + ROWS_W'(1);
				if (row_n >= rows_q) done_n = 1'b1;
			end
		end

		// Current byte of the last plane plus stored bytes of the earlier ones.
		v      = (st_q == ST_REPEAT) ? rep_byte_q : body_byte;
		pbytes = '0;
		for (int j = 0; j < LW; j++) pbytes[j] = rdata_s1[j];
		pbytes[PIDX_W'(pc_eff - PLANES_W'(1))] = v;
		for (int k = 0; k < 8; k++) begin
			for (int j = 0; j < 8; j++) begin
				pix_n[k][j] = pbytes[j][7-k] && (PLANES_W'(j) < pc_eff)
					&& (4'(k) < valid_n);
			end
		end
	end

	// Sequencer: run-length phases, repeat expansion and position counters.
	always_comb begin
		st_d       = st_q;
		phase_d    = phase_q;
		run_d      = run_q;
		column_d   = column_q;
		plane_d    = plane_q;
		row_d      = row_q;
		done_d     = done_q;
		rep_byte_d = rep_byte_q;
		rep_cnt_d  = rep_cnt_q;
		put        = 1'b0;
		last_copy  = 1'b1;
		run_dec    = run_q - RUN_W'(1);
		in_stall   = (st_q != ST_IDLE) || !emit_ok;

		case (st_q)
			ST_IDLE: begin
				if (in_acc && !done_q && (row_q < rows_q)) begin
					if (!compressed_q) begin
						put = 1'b1;
					end else begin
						case (phase_q)
							PH_CONTROL: begin
								if (body_byte < CTRL_NOP) begin
									run_d   = body_byte + RUN_W'(1);
									phase_d = PH_LITERAL;
								end else if (body_byte > CTRL_NOP) begin
									run_d   = RUN_W'(9'd257 - (BYTE_W+1)'(body_byte));
									phase_d = PH_REPEAT;
								end
							end
							PH_LITERAL: begin
								put   = 1'b1;
								run_d = run_dec;
								if (run_dec == '0) phase_d = PH_CONTROL;
								else if (plane_end || done_n) phase_d = PH_SKIP;
							end
							PH_REPEAT: begin
								put       = 1'b1;
								run_d     = '0;
								phase_d   = PH_CONTROL;
								last_copy = (run_q <= RUN_W'(1)) || plane_end;
								if (!last_copy) begin
									st_d       = ST_REPEAT;
									rep_cnt_d  = run_dec;
									rep_byte_d = body_byte;
								end
							end
							PH_SKIP: begin
								if (run_q != '0) run_d = run_dec;
								if (run_q <= RUN_W'(1)) phase_d = PH_CONTROL;
							end
							default: phase_d = PH_CONTROL;
						endcase
					end
				end
			end
			ST_REPEAT: begin
				last_copy = (rep_cnt_q <= RUN_W'(1)) || plane_end;
				if (!last_plane || emit_ok) begin
					put       = 1'b1;
					rep_cnt_d = rep_cnt_q - RUN_W'(1);
					if (last_copy) st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase

		if (put) begin
			column_d = col_n;
			plane_d  = plane_n;
			row_d    = row_n;
			done_d   = done_n;
		end

		// Any register write restarts decoding.
		if (cfg_we) begin
			st_d     = ST_IDLE;
			phase_d  = PH_CONTROL;
			run_d    = '0;
			column_d = '0;
			plane_d  = '0;
			row_d    = '0;
			done_d   = 1'b0;
		end

		mem_we   = put && !last_plane;
		out_load = put && last_plane;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= RST_WIDTH;
			rows_q       <= RST_ROWS;
			planes_q     <= RST_PLANES;
			compressed_q <= RST_COMPRESSED;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:      width_q      <= cfg_data[WIDTH_W-1:0];
				CFG_ROWS:       rows_q       <= cfg_data[ROWS_W-1:0];
				CFG_PLANES:     planes_q     <= cfg_data[PLANES_W-1:0];
				CFG_COMPRESSED: compressed_q <= cfg_data[0];
				default:        compressed_q <= compressed_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			phase_q   <= PH_CONTROL;
			run_q     <= '0;
			column_q  <= '0;
			plane_q   <= '0;
			row_q     <= '0;
			done_q    <= 1'b0;
			rep_cnt_q <= '0;
		end else begin
			st_q      <= st_d;
			phase_q   <= phase_d;
			run_q     <= run_d;
			column_q  <= column_d;
			plane_q   <= plane_d;
			row_q     <= row_d;
			done_q    <= done_d;
			rep_cnt_q <= rep_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		rep_byte_q <= rep_byte_d;
	end

	// The read address follows the next column, so the registered data of the
	// current column is always ready when that column becomes current.
	always_ff @(posedge clk) begin
		if (mem_we) row_mem[column_q][plane_q[LIW-1:0]] <= v;
		rdata_s1 <= row_mem[column_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_q   <= pix_n;
			valid_q <= valid_n;
			eor_q   <= eor_n;
			eoi_q   <= eoi_n;
			lor_q   <= last_copy;
		end
	end

	assign out_valid    = out_valid_q;
	assign pix0         = pix_q[0];
	assign pix1         = pix_q[1];
	assign pix2         = pix_q[2];
	assign pix3         = pix_q[3];
	assign pix4         = pix_q[4];
	assign pix5         = pix_q[5];
	assign pix6         = pix_q[6];
	assign pix7         = pix_q[7];
	assign valid_pixels = valid_q;
	assign end_of_row   = eor_q;
	assign end_of_image = eoi_q;
	assign last_of_run  = lor_q;

endmodule
